### rtl/core/bb3_pkg.sv
// Shared constants, types and helper functions of the 3x3 box blur block.
`default_nettype none
package bb3_pkg;

   // Largest frame the row stores can hold.
   localparam int unsigned MAX_WIDTH  = 1024;
   localparam int unsigned MAX_HEIGHT = 1024;

   // Counter and address widths follow from the frame limits.
   localparam int unsigned COL_W = $clog2(MAX_WIDTH);
   localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);

   // Fixed field widths of the channels and registers.
   localparam int unsigned CH_W    = 8;
   localparam int unsigned NUM_CH  = 3;
   localparam int unsigned PIX_W   = CH_W * NUM_CH;
   localparam int unsigned POS_W   = 10;
   localparam int unsigned CFG_W   = 11;
   localparam int unsigned CSR_IDX_W = 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

   // Reset values of the frame size registers.
   localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd320;
   localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd240;

   // Neighbourhood size and the divide-by-nine reciprocal.
   localparam int unsigned WIN_TAPS    = 9;
   localparam int unsigned WIN_COLS    = 6;
   localparam int unsigned SUM_W       = 12;
   localparam int unsigned RECIP_W     = 13;
   localparam int unsigned RECIP_SHIFT = 16;
   localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;

   // Bit positions of the three results one item can cause, in emission order.
   localparam int unsigned EMIT_NEIGH = 0;
   localparam int unsigned EMIT_MID   = 1;
   localparam int unsigned EMIT_OWN   = 2;
   localparam int unsigned EMIT_W     = 3;

   // Result queue depth and pointer widths.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH) + 1;

   typedef logic [PIX_W-1:0] pixel_type;

   // All results caused by one item, as held in the result queue.
   typedef struct packed {
      pixel_type         nb_pix;
      pixel_type         mid_pix;
      pixel_type         own_pix;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [EMIT_W-1:0] emit;
   } bundle_type;

   // Last valid index of a dimension after saturating it to 1..max_v.
   function automatic logic [15:0] last_index(input logic [CFG_W-1:0] v,
                                              input int unsigned max_v);
      logic [15:0] res;
      if (v == '0) begin
         res = '0;
      end else if (32'(v) > max_v) begin
         res = 16'(max_v - 1);
      end else begin
         res = 16'(v) - 16'd1;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

### rtl/core/bb3_stream_if.sv
// Valid/ready channel interfaces for pixel items and result items.
`default_nettype none
interface bb3_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_blue;
   logic [7:0] in_green;
   logic [7:0] in_red;

   modport source (output valid, in_blue, in_green, in_red, input ready);
   modport sink   (input valid, in_blue, in_green, in_red, output ready);
endinterface

interface bb3_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_blue;
   logic [7:0] out_green;
   logic [7:0] out_red;
   logic [9:0] out_row;
   logic [9:0] out_col;
   logic       last_of_run;

   modport source (output valid, out_blue, out_green, out_red, out_row, out_col,
                   last_of_run, input ready);
   modport sink   (input valid, out_blue, out_green, out_red, out_row, out_col,
                   last_of_run, output ready);
endinterface
`default_nettype wire

### rtl/core/box_blur_3x3_stream.sv
// 3x3 box blur over a raster-order stream of BGR pixels.
//
// Pixels enter on req_chan in raster order, one item per handshake. Each
// interior pixel leaves on rsp_chan as the truncated per-channel mean of its
// 3x3 neighbourhood; pixels of the first and last row and column leave as
// they came. Results carry their row and column, and last_of_run marks the
// final result caused by an input item. An item causes zero to three results.
// The first result of an item passes stage one, stage two, the result queue
// and the output register before it is offered. Items are taken one per
// cycle while the receiver is ready and each causes at most one result; the
// output then delivers one result per cycle, so items causing two or three
// results hold the input. Row stores are single-port-write memories read in
// the cycle before use, so the pixel rate is one per cycle when not stalled.
// A synchronous reset sets the frame to 320 x 240 and restarts at row 0,
// column 0. Writing either frame size register restarts the frame; write
// only while the block is idle. When the receiver stalls, results wait in
// the output register and queue; req_chan.ready falls at four items in flight.
`default_nettype none
module box_blur_3x3_stream (
   input  wire                         clock,
   input  wire                         reset,
   bb3_req_if.sink                     req_chan,
   bb3_rsp_if.source                   rsp_chan,
   input  wire                         csr_wr_en,
   input  wire [bb3_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [bb3_pkg::CFG_W-1:0]    csr_wdata
);
   import bb3_pkg::*;

   // Frame geometry and position counters.
   logic [COL_W-1:0]  wlast_ff, wlast_in;
   logic [ROW_W-1:0]  hlast_ff, hlast_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   // Stage one: memory read returns.
   logic              s1_valid_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   pixel_type         s1_pix_ff;
   logic [EMIT_W-1:0] s1_emit_ff;
   logic              s1_edge_ff;
   logic              s1_fwd_ff;
   pixel_type         s1_fwd_top_ff;
   pixel_type         s1_fwd_mid_ff;
   pixel_type         older_rd_ff;
   pixel_type         newer_rd_ff;
   pixel_type         s1_top;
   pixel_type         s1_mid;
   logic [SUM_W-1:0]  s1_sum [NUM_CH];

   // Row stores.
   pixel_type         older_mem [MAX_WIDTH];
   pixel_type         newer_mem [MAX_WIDTH];

   // Window of the two previous columns: top, middle, bottom each.
   pixel_type         win_ff [WIN_COLS];

   // Stage two: divide by nine.
   logic              s2_valid_ff;
   logic [SUM_W-1:0]  s2_sum_ff [NUM_CH];
   logic              s2_edge_ff;
   pixel_type         s2_edge_pix_ff;
   pixel_type         s2_mid_ff;
   pixel_type         s2_pix_ff;
   logic [ROW_W-1:0]  s2_row_ff;
   logic [COL_W-1:0]  s2_col_ff;
   logic [EMIT_W-1:0] s2_emit_ff;
   pixel_type         s2_mean;
   bundle_type        s2_bundle;

   // Result queue.
   bundle_type        queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] in_flight;
   logic              push;
   logic              pop;

   // Output serialiser and output register.
   bundle_type        head;
   logic [EMIT_W-1:0] done_ff;
   logic [EMIT_W-1:0] pend;
   logic [EMIT_W-1:0] sel;
   logic              sel_last;
   logic              load;
   logic              rsp_valid_ff;
   pixel_type         rsp_pix_ff, rsp_pix_in;
   logic [POS_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [POS_W-1:0]  rsp_col_ff, rsp_col_in;
   logic              rsp_last_ff;

   logic              accept;
   logic              last_col;

   // Input handshake: room for every item still in flight.
   assign in_flight = count_ff + QCNT_W'(s1_valid_ff) + QCNT_W'(s2_valid_ff);
   assign req_chan.ready = (in_flight < QCNT_W'(QUEUE_DEPTH));
   assign accept = req_chan.valid && req_chan.ready;
   assign last_col = (col_ff == wlast_ff);

   // Next frame geometry from a register write.
   always_comb begin
      wlast_in = wlast_ff;
      hlast_in = hlast_ff;
      if (csr_wr_en && csr_index == REG_FRAME_WIDTH) begin
         wlast_in = COL_W'(last_index(csr_wdata, MAX_WIDTH));
      end
      if (csr_wr_en && csr_index == REG_FRAME_HEIGHT) begin
         hlast_in = ROW_W'(last_index(csr_wdata, MAX_HEIGHT));
      end
   end

   // Position of the next item in the frame.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_wr_en) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = (row_ff >= hlast_ff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff <= COL_W'(last_index(RESET_WIDTH, MAX_WIDTH));
         hlast_ff <= ROW_W'(last_index(RESET_HEIGHT, MAX_HEIGHT));
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         wlast_ff <= wlast_in;
         hlast_ff <= hlast_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   // Stage one capture. An item whose column was written back by the item
   // ahead of it in the same cycle takes that item's values directly.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_col_ff <= col_ff;
         s1_row_ff <= row_ff;
         s1_pix_ff <= {req_chan.in_red, req_chan.in_green, req_chan.in_blue};
         s1_emit_ff[EMIT_NEIGH] <= (row_ff >= ROW_W'(2)) && (col_ff != '0);
         s1_emit_ff[EMIT_MID]   <= (row_ff >= ROW_W'(2)) && last_col;
         s1_emit_ff[EMIT_OWN]   <= (row_ff == '0) || (row_ff == hlast_ff);
         s1_edge_ff    <= (col_ff == COL_W'(1));
         s1_fwd_ff     <= s1_valid_ff && (s1_col_ff == col_ff);
         s1_fwd_top_ff <= s1_mid;
         s1_fwd_mid_ff <= s1_pix_ff;
      end
   end

   // Row store access: read ahead at accept, write back in stage one.
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         older_mem[s1_col_ff] <= s1_mid;
         newer_mem[s1_col_ff] <= s1_pix_ff;
      end
      if (accept) begin
         older_rd_ff <= older_mem[col_ff];
         newer_rd_ff <= newer_mem[col_ff];
      end
   end

   assign s1_top = s1_fwd_ff ? s1_fwd_top_ff : older_rd_ff;
   assign s1_mid = s1_fwd_ff ? s1_fwd_mid_ff : newer_rd_ff;

   // Per-channel sum of the nine neighbourhood pixels.
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         s1_sum[ch] = SUM_W'(s1_top[ch*CH_W +: CH_W]) + SUM_W'(s1_mid[ch*CH_W +: CH_W])
                    + SUM_W'(s1_pix_ff[ch*CH_W +: CH_W]);
         for (int k = 0; k < WIN_COLS; k++) begin
            s1_sum[ch] = s1_sum[ch] + SUM_W'(win_ff[k][ch*CH_W +: CH_W]);
         end
      end
   end

   // Window shift: the oldest column drops out as this item's column enters.
   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         for (int k = 0; k < WIN_COLS; k++) begin
            win_ff[k] <= '0;
         end
      end else if (s1_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= s1_top;
         win_ff[4] <= s1_mid;
         win_ff[5] <= s1_pix_ff;
      end
   end

   // Stage two capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s1_valid_ff) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            s2_sum_ff[ch] <= s1_sum[ch];
         end
         s2_edge_ff     <= s1_edge_ff;
         s2_edge_pix_ff <= win_ff[4];
         s2_mid_ff      <= s1_mid;
         s2_pix_ff      <= s1_pix_ff;
         s2_row_ff      <= s1_row_ff;
         s2_col_ff      <= s1_col_ff;
         s2_emit_ff     <= s1_emit_ff;
      end
   end

   // Divide by nine through the reciprocal; exact for sums below 2**15.
   always_comb begin
      logic [SUM_W+RECIP_W-1:0] prod;
      prod = '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         prod = SUM_W'(s2_sum_ff[ch]) * RECIP_NINE;
         s2_mean[ch*CH_W +: CH_W] = prod[RECIP_SHIFT +: CH_W];
      end
   end

   // A column-one neighbour is the first-column pixel passed through.
   always_comb begin
      s2_bundle.nb_pix  = s2_edge_ff ? s2_edge_pix_ff : s2_mean;
      s2_bundle.mid_pix = s2_mid_ff;
      s2_bundle.own_pix = s2_pix_ff;
      s2_bundle.row     = s2_row_ff;
      s2_bundle.col     = s2_col_ff;
      s2_bundle.emit    = s2_emit_ff;
   end

   assign push = s2_valid_ff && (s2_emit_ff != '0);

   // Result queue of per-item bundles.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= s2_bundle;
      end
   end

   // Pick the next pending result of the head bundle, in emission order.
   assign head = queue_ff[rd_ptr_ff];
   assign pend = head.emit & ~done_ff;
   assign load = (count_ff != '0) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      sel = '0;
      if (pend[EMIT_NEIGH]) begin
         sel[EMIT_NEIGH] = 1'b1;
      end else if (pend[EMIT_MID]) begin
         sel[EMIT_MID] = 1'b1;
      end else begin
         sel[EMIT_OWN] = 1'b1;
      end
      sel_last = ((pend & ~sel) == '0);
      pop = load && sel_last;
   end

   // Payload and position of the selected result.
   always_comb begin
      rsp_pix_in = head.own_pix;
      rsp_row_in = POS_W'(head.row);
      rsp_col_in = POS_W'(head.col);
      if (sel[EMIT_NEIGH]) begin
         rsp_pix_in = head.nb_pix;
         rsp_row_in = POS_W'(head.row - 1'b1);
         rsp_col_in = POS_W'(head.col - 1'b1);
      end else if (sel[EMIT_MID]) begin
         rsp_pix_in = head.mid_pix;
         rsp_row_in = POS_W'(head.row - 1'b1);
      end
   end

   // Output register and the record of results already sent from the head.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         done_ff      <= '0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            done_ff      <= sel_last ? '0 : (done_ff | sel);
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (load) begin
         rsp_pix_ff  <= rsp_pix_in;
         rsp_row_ff  <= rsp_row_in;
         rsp_col_ff  <= rsp_col_in;
         rsp_last_ff <= sel_last;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_blue    = rsp_pix_ff[0*CH_W +: CH_W];
   assign rsp_chan.out_green   = rsp_pix_ff[1*CH_W +: CH_W];
   assign rsp_chan.out_red     = rsp_pix_ff[2*CH_W +: CH_W];
   assign rsp_chan.out_row     = rsp_row_ff;
   assign rsp_chan.out_col     = rsp_col_ff;
   assign rsp_chan.last_of_run = rsp_last_ff;

endmodule
`default_nettype wire

### bench/tb.sv
// Self-checking testbench for the 3x3 box blur stream: directed table, random frames, extremes.
`default_nettype none
module tb;
   import bb3_pkg::*;

   // One result item as the block presents it.
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [9:0] row;
      logic [9:0] col;
      logic       last;
   } blur_out_type;

   // One row of the directed table; want is used only where typed is set.
   typedef struct packed {
      logic [1:0]   phase;
      logic [7:0]   blue;
      logic [7:0]   green;
      logic [7:0]   red;
      logic         typed;
      blur_out_type want;
   } plan_row_type;

   localparam blur_out_type NO_TYPED = '0;
   localparam int unsigned PLAN_LEN = 22;
   localparam int unsigned RANDOM_ITEMS = 72;
   localparam int unsigned EXTREME_ITEMS = 8;
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned LONG_HOLD = 80;

   // Frame size per directed phase; phase 0 runs on the reset size.
   localparam int unsigned PHASE_WIDTH [4] = '{320, 3, 0, 2};
   localparam int unsigned PHASE_HEIGHT [4] = '{240, 3, 0, 2};

   localparam plan_row_type PLAN [PLAN_LEN] = '{
      // Reset frame, first row: pixels pass straight through.
      '{2'd0, 8'h00, 8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 8'h00, 10'd0, 10'd0, 1'b1}},
      '{2'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 10'd0, 10'd1, 1'b1}},
      '{2'd0, 8'hAA, 8'h55, 8'hAA, 1'b1, '{8'hAA, 8'h55, 8'hAA, 10'd0, 10'd2, 1'b1}},
      '{2'd0, 8'h55, 8'hAA, 8'h55, 1'b1, '{8'h55, 8'hAA, 8'h55, 10'd0, 10'd3, 1'b1}},
      // Smallest frame with an interior pixel, extremes around it.
      '{2'd1, 8'hFF, 8'hFF, 8'hFF, 1'b0, NO_TYPED},
      '{2'd1, 8'h00, 8'h00, 8'h00, 1'b0, NO_TYPED},
      '{2'd1, 8'hFF, 8'h00, 8'h80, 1'b0, NO_TYPED},
      '{2'd1, 8'h01, 8'h02, 8'h03, 1'b0, NO_TYPED},
      '{2'd1, 8'hFE, 8'hFD, 8'hFC, 1'b0, NO_TYPED},
      '{2'd1, 8'h80, 8'h7F, 8'h7E, 1'b0, NO_TYPED},
      '{2'd1, 8'hFF, 8'hFF, 8'hFF, 1'b0, NO_TYPED},
      '{2'd1, 8'h07, 8'h08, 8'h09, 1'b0, NO_TYPED},
      '{2'd1, 8'h00, 8'hFF, 8'h00, 1'b0, NO_TYPED},
      // Zero sizes saturate to a single pixel frame that wraps on every item.
      '{2'd2, 8'h0C, 8'h22, 8'h38, 1'b1, '{8'h0C, 8'h22, 8'h38, 10'd0, 10'd0, 1'b1}},
      '{2'd2, 8'hFF, 8'h00, 8'hFF, 1'b1, '{8'hFF, 8'h00, 8'hFF, 10'd0, 10'd0, 1'b1}},
      '{2'd2, 8'h00, 8'hFF, 8'h00, 1'b1, '{8'h00, 8'hFF, 8'h00, 10'd0, 10'd0, 1'b1}},
      // Two by two frame: both rows are edges, then the frame wraps.
      '{2'd3, 8'h01, 8'h02, 8'h04, 1'b1, '{8'h01, 8'h02, 8'h04, 10'd0, 10'd0, 1'b1}},
      '{2'd3, 8'h08, 8'h10, 8'h20, 1'b1, '{8'h08, 8'h10, 8'h20, 10'd0, 10'd1, 1'b1}},
      '{2'd3, 8'h40, 8'h80, 8'hFE, 1'b1, '{8'h40, 8'h80, 8'hFE, 10'd1, 10'd0, 1'b1}},
      '{2'd3, 8'hFD, 8'hFB, 8'hF7, 1'b1, '{8'hFD, 8'hFB, 8'hF7, 10'd1, 10'd1, 1'b1}},
      '{2'd3, 8'hEF, 8'hDF, 8'hBF, 1'b1, '{8'hEF, 8'hDF, 8'hBF, 10'd0, 10'd0, 1'b1}},
      '{2'd3, 8'h7F, 8'h00, 8'h80, 1'b1, '{8'h7F, 8'h00, 8'h80, 10'd0, 10'd1, 1'b1}}
   };

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   bb3_req_if pixel_in ();
   bb3_rsp_if pixel_out ();

   box_blur_3x3_stream i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (pixel_in),
      .rsp_chan  (pixel_out),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Blur state as the predictor sees it.
   pixel_type        line_two_up [MAX_WIDTH];
   pixel_type        line_one_up [MAX_WIDTH];
   pixel_type        recent_cols [WIN_COLS];
   int unsigned      next_row;
   int unsigned      next_col;
   logic [CFG_W-1:0] cfg_width;
   logic [CFG_W-1:0] cfg_height;

   blur_out_type blurred_due [$];
   blur_out_type step_out [$];
   int unsigned  fault_count;
   bit           hold_request;
   int unsigned  steady_left;

   initial begin
      cfg_width = RESET_WIDTH;
      cfg_height = RESET_HEIGHT;
      next_row = 0;
      next_col = 0;
      foreach (recent_cols[k]) recent_cols[k] = '0;
      fault_count = 0;
      hold_request = 1'b0;
      steady_left = 0;
   end

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
   end

   // Saturate a size register to the range the block supports.
   function automatic int unsigned usable_size(input logic [CFG_W-1:0] v, input int unsigned hi);
      if (v == '0) return 1;
      if (32'(v) > hi) return hi;
      return 32'(v);
   endfunction

   task automatic add_result(input pixel_type p, input int unsigned row, input int unsigned col);
      step_out.push_back('{p[7:0], p[15:8], p[23:16], 10'(row), 10'(col), 1'b0});
   endtask

   // Work out the results of one accepted pixel and advance the blur state.
   task automatic predict_blur(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
      pixel_type   pix;
      pixel_type   above;
      pixel_type   beside;
      pixel_type   blurred;
      pixel_type   taps [WIN_TAPS];
      int unsigned w_eff;
      int unsigned h_eff;
      int unsigned sum;
      bit          last_col;
      step_out.delete();
      w_eff = usable_size(cfg_width, MAX_WIDTH);
      h_eff = usable_size(cfg_height, MAX_HEIGHT);
      pix = {r, g, b};
      above = line_two_up[next_col];
      beside = line_one_up[next_col];
      last_col = (next_col == w_eff - 1);

      if (next_row >= 2) begin
         if (next_col >= 1) begin
            // Column zero of the row above is an edge and leaves unchanged.
            if (next_col == 1) begin
               blurred = recent_cols[4];
            end else begin
               for (int t = 0; t < WIN_COLS; t++) taps[t] = recent_cols[t];
               taps[6] = above;
               taps[7] = beside;
               taps[8] = pix;
               for (int ch = 0; ch < NUM_CH; ch++) begin
                  sum = 0;
                  for (int t = 0; t < WIN_TAPS; t++) sum += taps[t][ch*CH_W +: CH_W];
                  blurred[ch*CH_W +: CH_W] = CH_W'(sum / WIN_TAPS);
               end
            end
            add_result(blurred, next_row - 1, next_col - 1);
         end
         if (last_col) add_result(beside, next_row - 1, next_col);
      end
      if (next_row == 0 || next_row == h_eff - 1) add_result(pix, next_row, next_col);
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;

      for (int t = 0; t < 3; t++) recent_cols[t] = recent_cols[t + 3];
      recent_cols[3] = above;
      recent_cols[4] = beside;
      recent_cols[5] = pix;
      line_two_up[next_col] = beside;
      line_one_up[next_col] = pix;

      if (last_col) begin
         next_col = 0;
         next_row = (next_row >= h_eff - 1) ? 0 : next_row + 1;
      end else begin
         next_col++;
      end
   endtask

   // Mostly no gap, sometimes a short one, rarely a long one; runs of no gaps now and then.
   function automatic int unsigned pick_pause();
      int unsigned roll;
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         steady_left = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 70) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] rand_channel();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int unsigned pick_size();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll < 12) return $urandom_range(1, 6);
      if (roll < 16) return $urandom_range(7, 16);
      if (roll < 17) return 0;
      if (roll < 18) return 1024;
      return $urandom_range(1025, 2047);
   endfunction

   // Offer one pixel, starting at a falling edge; returns at the falling edge after acceptance.
   task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                             input bit typed, input blur_out_type want);
      int unsigned pause;
      pause = pick_pause();
      if (pause > 0) begin
         pixel_in.valid <= 1'b0;
         repeat (pause) @(negedge clock);
      end
      pixel_in.valid <= 1'b1;
      pixel_in.in_blue <= b;
      pixel_in.in_green <= g;
      pixel_in.in_red <= r;
      do @(posedge clock); while (!pixel_in.ready);
      predict_blur(b, g, r);
      if (typed) begin
         blurred_due.push_back(want);
      end else begin
         foreach (step_out[k]) blurred_due.push_back(step_out[k]);
      end
      @(negedge clock);
   endtask

   // Stop offering items until every expected result has arrived, then let the block settle.
   task automatic wait_idle(input int unsigned settle);
      pixel_in.valid <= 1'b0;
      do @(negedge clock); while (blurred_due.size() != 0);
      repeat (settle) @(negedge clock);
   endtask

   // Write both size registers; either write restarts the frame.
   task automatic set_frame(input int unsigned w, input int unsigned h);
      csr_wr_en <= 1'b1;
      csr_index <= REG_FRAME_WIDTH;
      csr_wdata <= CFG_W'(w);
      @(negedge clock);
      csr_index <= REG_FRAME_HEIGHT;
      csr_wdata <= CFG_W'(h);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cfg_width = CFG_W'(w);
      cfg_height = CFG_W'(h);
      next_row = 0;
      next_col = 0;
      foreach (recent_cols[k]) recent_cols[k] = '0;
   endtask

   // Stimulus: directed table, random frames, then the largest width and height.
   initial begin : pixel_source
      int unsigned phase_now;
      int unsigned phase_no;
      int unsigned random_sent;
      int unsigned w;
      int unsigned h;
      int unsigned count;
      pixel_in.valid = 1'b0;
      pixel_in.in_blue = '0;
      pixel_in.in_green = '0;
      pixel_in.in_red = '0;
      csr_wr_en = 1'b0;
      csr_index = REG_FRAME_WIDTH;
      csr_wdata = '0;
      do @(negedge clock); while (reset);

      phase_now = 0;
      foreach (PLAN[i]) begin
         if (PLAN[i].phase != phase_now) begin
            phase_now = PLAN[i].phase;
            wait_idle(SETTLE_CYCLES);
            set_frame(PHASE_WIDTH[phase_now], PHASE_HEIGHT[phase_now]);
         end
         send_pixel(PLAN[i].blue, PLAN[i].green, PLAN[i].red, PLAN[i].typed, PLAN[i].want);
      end

      // Random frames: mostly small, whole frames plus a partial one.
      phase_no = 0;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (phase_no == 0) begin
            w = $urandom_range(4, 8);
            h = $urandom_range(3, 6);
         end else begin
            w = pick_size();
            h = pick_size();
         end
         wait_idle(SETTLE_CYCLES);
         set_frame(w, h);
         count = usable_size(w, MAX_WIDTH) * usable_size(h, MAX_HEIGHT) * $urandom_range(1, 2)
                 + $urandom_range(0, usable_size(w, MAX_WIDTH));
         if (count > 48) count = $urandom_range(24, 48);
         if (count > RANDOM_ITEMS - random_sent) count = RANDOM_ITEMS - random_sent;
         // The receiver holds off for a long stretch so the block fills up and stalls.
         if (phase_no == 0 || $urandom_range(0, 7) == 0) hold_request = 1'b1;
         for (int k = 0; k < count; k++) begin
            if (k == count / 2 && (phase_no == 1 || $urandom_range(0, 3) == 0)) wait_idle(0);
            send_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0, NO_TYPED);
         end
         random_sent += count;
         phase_no++;
      end

      // Start of the widest row, saturated from an oversized value, as a single-row frame.
      wait_idle(SETTLE_CYCLES);
      set_frame(1500, 1);
      for (int k = 0; k < EXTREME_ITEMS; k++)
         send_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0, NO_TYPED);

      // Top of the tallest frame, one column wide, saturated from the largest register value.
      wait_idle(SETTLE_CYCLES);
      set_frame(1, 2047);
      for (int k = 0; k < EXTREME_ITEMS; k++)
         send_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0, NO_TYPED);

      wait_idle(SETTLE_CYCLES * 2);
      if (fault_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Result side readiness: random short and long stalls, calm stretches, long hold-offs on request.
   initial begin : result_sink
      int unsigned stall_left;
      int unsigned calm_left;
      int unsigned roll;
      stall_left = 0;
      calm_left = 0;
      pixel_out.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            pixel_out.ready <= 1'b0;
         end else begin
            pixel_out.ready <= 1'b1;
            if (calm_left > 0) begin
               calm_left--;
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 10) stall_left = $urandom_range(1, 3);
               else if (roll < 13) stall_left = $urandom_range(10, 40);
               else if (roll < 16) calm_left = $urandom_range(30, 100);
            end
         end
      end
   end

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fault_count++;
      end
   endtask

   // Each accepted result is matched against the oldest expectation.
   always @(posedge clock) begin : result_check
      blur_out_type want;
      if (!reset && pixel_out.valid && pixel_out.ready) begin
         if (blurred_due.size() == 0) begin
            $error("result with nothing expected: row %0d col %0d",
                   pixel_out.out_row, pixel_out.out_col);
            fault_count++;
         end else begin
            want = blurred_due.pop_front();
            compare_field("out_blue", want.blue, pixel_out.out_blue);
            compare_field("out_green", want.green, pixel_out.out_green);
            compare_field("out_red", want.red, pixel_out.out_red);
            compare_field("out_row", want.row, pixel_out.out_row);
            compare_field("out_col", want.col, pixel_out.out_col);
            compare_field("last_of_run", want.last, pixel_out.last_of_run);
         end
      end
   end

   // Give up if the run hangs.
   initial begin : watchdog
      #30_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
`default_nettype wire

### sim.f
rtl/core/bb3_pkg.sv
rtl/core/bb3_stream_if.sv
rtl/core/box_blur_3x3_stream.sv
bench/tb.sv
